/* rtl/core/aqts_pkg.sv */
// shared types and constants of the armed quarter trigger sequencer
package aqts_pkg;

   localparam int MV_W           = 15;
   localparam int CH_N           = 4;
   localparam int TRIG_N         = CH_N + 2;
   localparam int STEPS          = 16;
   localparam int POS_W          = $clog2(STEPS) + 1;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 16;
   localparam int PULSE_BITS_DEF = 16;

   localparam logic [POS_W-1:0]         POS_RESET      = POS_W'(STEPS);
   localparam logic [CSR_DATA_W-1:0]    PULSE_RESET    = CSR_DATA_W'(48);
   localparam logic signed [MV_W-1:0]   TRIG_HIGH_RST  = MV_W'(1000);
   localparam logic signed [MV_W-1:0]   TRIG_LOW_RST   = MV_W'(0);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GATE_MODE     = 2'd0,
      CSR_PULSE_SAMPLES = 2'd1,
      CSR_TRIG_HIGH     = 2'd2,
      CSR_TRIG_LOW      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                     gate_mode;
      logic [CSR_DATA_W-1:0]    pulse_samples;
      logic signed [MV_W-1:0]   trig_high;
      logic signed [MV_W-1:0]   trig_low;
   } cfg_type;

   typedef struct packed {
      logic              clk_rise;
      logic              rst_rise;
      logic [CH_N-1:0]   arm_rise;
   } evt_type;

endpackage

/* rtl/core/aqts_csr.sv */
// configuration registers
module aqts_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [aqts_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [aqts_pkg::CSR_DATA_W-1:0] csr_data,
   output aqts_pkg::cfg_type               cfg
);
   import aqts_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_GATE_MODE:     cfg_in.gate_mode     = csr_data[0];
            CSR_PULSE_SAMPLES: cfg_in.pulse_samples = csr_data;
            CSR_TRIG_HIGH:     cfg_in.trig_high     = csr_data[MV_W-1:0];
            CSR_TRIG_LOW:      cfg_in.trig_low      = csr_data[MV_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gate_mode     <= 1'b0;
         cfg_ff.pulse_samples <= PULSE_RESET;
         cfg_ff.trig_high     <= TRIG_HIGH_RST;
         cfg_ff.trig_low      <= TRIG_LOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/core/aqts_trig.sv */
// schmitt triggers for clock, reset and the four arm inputs
module aqts_trig (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              fire,
   input  aqts_pkg::cfg_type                 cfg,
   input  logic signed [aqts_pkg::MV_W-1:0]  clock_mv,
   input  logic signed [aqts_pkg::MV_W-1:0]  reset_mv,
   input  logic signed [aqts_pkg::MV_W-1:0]  arm_mv [aqts_pkg::CH_N],
   output aqts_pkg::evt_type                 evt
);
   import aqts_pkg::*;

   logic [TRIG_N-1:0] state_ff;
   logic [TRIG_N-1:0] state_in;

   // returns {rise, new state}
   function automatic logic [1:0] schmitt(input logic cur, input logic signed [MV_W-1:0] mv,
                                          input logic signed [MV_W-1:0] hi,
                                          input logic signed [MV_W-1:0] lo);
      logic [1:0] r;
      r = {1'b0, cur};
      if (cur) begin
         if (mv <= lo) r = 2'b00;
      end else if (mv >= hi) begin
         r = 2'b11;
      end
      return r;
   endfunction

   always_comb begin
      logic [1:0]        r_rst;
      logic [1:0]        r_clk;
      logic [1:0]        r_arm;
      logic [TRIG_N-1:0] st;
      st    = state_ff;
      r_rst = schmitt(state_ff[1], reset_mv, cfg.trig_high, cfg.trig_low);
      r_clk = schmitt(state_ff[0], clock_mv, cfg.trig_high, cfg.trig_low);
      st[1] = r_rst[0];
      st[0] = r_clk[0];
      evt.rst_rise = r_rst[1];
      evt.clk_rise = r_clk[1];
      for (int i = 0; i < CH_N; i++) begin
         // a reset edge drops the arm triggers before they see this sample
         r_arm = schmitt(state_ff[2+i] & ~r_rst[1], arm_mv[i], cfg.trig_high, cfg.trig_low);
         st[2+i]         = r_arm[0];
         evt.arm_rise[i] = r_arm[1];
      end
      state_in = fire ? st : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/aqts_seq.sv */
// step position, arm and gate flags, pulse timers
module aqts_seq #(
   parameter int PULSE_BITS = aqts_pkg::PULSE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  aqts_pkg::cfg_type             cfg,
   input  aqts_pkg::evt_type             evt,
   input  logic [aqts_pkg::CH_N-1:0]     arm_buttons,
   output logic [aqts_pkg::CH_N-1:0]     out_gates,
   output logic [aqts_pkg::CH_N-1:0]     armed_lights,
   output logic [aqts_pkg::POS_W-1:0]    position
);
   import aqts_pkg::*;

   localparam int LW = (PULSE_BITS > CSR_DATA_W) ? PULSE_BITS : CSR_DATA_W;
   localparam logic [LW-1:0] PMAX = LW'({PULSE_BITS{1'b1}});

   logic [POS_W-1:0]      pos_ff,   pos_in;
   logic [CH_N-1:0]       armed_ff, armed_in;
   logic [CH_N-1:0]       gate_ff,  gate_in;
   logic [PULSE_BITS-1:0] pulse_ff [CH_N];
   logic [PULSE_BITS-1:0] pulse_in [CH_N];
   logic [PULSE_BITS-1:0] len;

   // pulse length saturated to the timer range
   always_comb begin
      logic [LW-1:0] ext;
      ext = LW'(cfg.pulse_samples);
      len = (ext > PMAX) ? PULSE_BITS'(PMAX) : PULSE_BITS'(ext);
   end

   always_comb begin
      logic [POS_W-1:0]      pos;
      logic [CH_N-1:0]       armed;
      logic [CH_N-1:0]       gate;
      logic [PULSE_BITS-1:0] pulse [CH_N];
      logic [CH_N-1:0]       outs;
      logic [1:0]            ch;
      pos   = pos_ff;
      armed = armed_ff;
      gate  = gate_ff;
      pulse = pulse_ff;
      outs  = '0;
      ch    = '0;
      if (evt.rst_rise) begin
         pos   = POS_RESET;
         armed = '0;
         gate  = '0;
      end
      if (evt.clk_rise) begin
         pos = (pos >= POS_W'(STEPS - 1)) ? '0 : pos + POS_W'(1);
         if (pos[1:0] == 2'd0) begin
            ch = pos[3:2];
            // previous quarter's gate closes
            gate[ch - 2'd1] = 1'b0;
            if (armed[ch]) begin
               if (len > pulse[ch]) pulse[ch] = len;
               if (cfg.gate_mode) gate[ch] = 1'b1;
               armed[ch] = 1'b0;
            end
         end
      end
      for (int i = 0; i < CH_N; i++) begin
         armed[i] = armed[i] | arm_buttons[i] | evt.arm_rise[i];
         outs[i]  = (pulse[i] != '0) | gate[i];
         if (pulse[i] != '0) pulse[i] = pulse[i] - PULSE_BITS'(1);
      end
      out_gates    = outs;
      armed_lights = armed;
      position     = pos;
      pos_in   = fire ? pos   : pos_ff;
      armed_in = fire ? armed : armed_ff;
      gate_in  = fire ? gate  : gate_ff;
      for (int i = 0; i < CH_N; i++) pulse_in[i] = fire ? pulse[i] : pulse_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_RESET;
         armed_ff <= '0;
         gate_ff  <= '0;
         for (int i = 0; i < CH_N; i++) pulse_ff[i] <= '0;
      end else begin
         pos_ff   <= pos_in;
         armed_ff <= armed_in;
         gate_ff  <= gate_in;
         pulse_ff <= pulse_in;
      end
   end

endmodule

/* rtl/core/armed_quarter_trigger_sequencer_core.sv */
// top level of the armed quarter trigger sequencer
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    clock, reset, arm0..3 mv, arm_buttons
//   rsp      out        rsp_valid/stall    out_gates, armed_lights, position
//   csr      in         csr_valid/ready    csr_index, csr_data
//
// one item per cycle while rsp is not stalled; a taken item reaches rsp in this order
// (input register, then trigger and sequencer logic into the result register)
// the state loop (triggers, position, flags, timers) updates its registers on each fired item
// synchronous reset clears control state and restores register defaults
// a stalled result holds the item in the input register, which stalls req
module armed_quarter_trigger_sequencer_core #(
   parameter int PULSE_BITS = aqts_pkg::PULSE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [aqts_pkg::MV_W-1:0]    req_clock_mv,
   input  logic signed [aqts_pkg::MV_W-1:0]    req_reset_mv,
   input  logic signed [aqts_pkg::MV_W-1:0]    req_arm0_mv,
   input  logic signed [aqts_pkg::MV_W-1:0]    req_arm1_mv,
   input  logic signed [aqts_pkg::MV_W-1:0]    req_arm2_mv,
   input  logic signed [aqts_pkg::MV_W-1:0]    req_arm3_mv,
   input  logic [aqts_pkg::CH_N-1:0]           req_arm_buttons,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [aqts_pkg::CH_N-1:0]           rsp_out_gates,
   output logic [aqts_pkg::CH_N-1:0]           rsp_armed_lights,
   output logic [aqts_pkg::POS_W-1:0]          rsp_position,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [aqts_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [aqts_pkg::CSR_DATA_W-1:0]     csr_data
);
   import aqts_pkg::*;

   cfg_type cfg;
   evt_type evt;

   logic                   in_valid_ff, in_valid_in;
   logic signed [MV_W-1:0] clock_mv_ff, reset_mv_ff;
   logic signed [MV_W-1:0] arm_mv_ff [CH_N];
   logic [CH_N-1:0]        buttons_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CH_N-1:0]        gates_ff, lights_ff;
   logic [POS_W-1:0]       pos_ff;
   logic [CH_N-1:0]        gates_nx, lights_nx;
   logic [POS_W-1:0]       pos_nx;

   logic take, fire, rsp_open;

   assign take      = req_valid && !req_stall;
   assign rsp_open  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && rsp_open;
   assign req_stall = in_valid_ff && !rsp_open;

   assign in_valid_in  = take | (in_valid_ff & ~fire);
   assign rsp_valid_in = fire | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         clock_mv_ff  <= req_clock_mv;
         reset_mv_ff  <= req_reset_mv;
         arm_mv_ff[0] <= req_arm0_mv;
         arm_mv_ff[1] <= req_arm1_mv;
         arm_mv_ff[2] <= req_arm2_mv;
         arm_mv_ff[3] <= req_arm3_mv;
         buttons_ff   <= req_arm_buttons;
      end
      if (fire) begin
         gates_ff  <= gates_nx;
         lights_ff <= lights_nx;
         pos_ff    <= pos_nx;
      end
   end

   aqts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   aqts_trig u_trig (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .cfg      (cfg),
      .clock_mv (clock_mv_ff),
      .reset_mv (reset_mv_ff),
      .arm_mv   (arm_mv_ff),
      .evt      (evt)
   );

   aqts_seq #(
      .PULSE_BITS (PULSE_BITS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .cfg          (cfg),
      .evt          (evt),
      .arm_buttons  (buttons_ff),
      .out_gates    (gates_nx),
      .armed_lights (lights_nx),
      .position     (pos_nx)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_gates    = gates_ff;
   assign rsp_armed_lights = lights_ff;
   assign rsp_position     = pos_ff;

   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("item in input register did not reach the result register");

   a_position_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_position <= POS_W'(STEPS)))
      else $error("position beyond reset value");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("req stalled without a blocked result");

endmodule
